@@ hdl/dis_pkg.sv @@
package dis_pkg;

    localparam int MAX_INTERVALS_DEF = 16;
    localparam int VALUE_WIDTH_DEF   = 16;
    localparam int STATUS_W          = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED   = 3'd0,
        ST_PRESENT = 3'd1,
        ST_FULL    = 3'd2,
        ST_RECORD  = 3'd3,
        ST_EMPTY   = 3'd4
    } t_status;

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_DUMP = 1'b1
    } t_opcode;

    // Control half of a result handed from the sequencer to the output stage.
    typedef struct packed {
        logic    valid;
        t_status status;
        logic    last;
    } t_rslt_ctl;

endpackage

@@ hdl/dis_if.sv @@
interface dis_req_if import dis_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) ();
    logic                   valid;
    logic                   ready;
    logic                   opcode;
    logic [VALUE_WIDTH-1:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface dis_rsp_if import dis_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int COUNT_WIDTH = $clog2(MAX_INTERVALS_DEF + 1)
) ();
    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [VALUE_WIDTH-1:0] interval_start;
    logic [VALUE_WIDTH-1:0] interval_end;
    logic [COUNT_WIDTH-1:0] interval_count;
    logic                   last_of_run;

    modport source (output valid, output status, output interval_start,
                    output interval_end, output interval_count, output last_of_run,
                    input ready);
    modport sink   (input valid, input status, input interval_start,
                    input interval_end, input interval_count, input last_of_run,
                    output ready);
endinterface

@@ hdl/dis_ram.sv @@
module dis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/dis_seq.sv @@
module dis_seq import dis_pkg::*; #(
    parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
    parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
    localparam int AW           = $clog2(MAX_INTERVALS),
    localparam int CW           = $clog2(MAX_INTERVALS + 1),
    localparam int DW           = 2 * VALUE_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    dis_req_if.sink                i_req,
    output logic                   o_ram_wr_en,
    output logic [AW-1:0]          o_ram_wr_addr,
    output logic [DW-1:0]          o_ram_wr_data,
    output logic                   o_ram_rd_en,
    output logic [AW-1:0]          o_ram_rd_addr,
    input  logic [DW-1:0]          i_ram_rd_data,
    output t_rslt_ctl              o_rslt,
    output logic [VALUE_WIDTH-1:0] o_rslt_start,
    output logic [VALUE_WIDTH-1:0] o_rslt_end,
    output logic [CW-1:0]          o_rslt_count,
    input  logic                   i_rslt_free
);

    localparam int VW = VALUE_WIDTH;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_DECIDE = 7'b0000100,
        S_SHIFT  = 7'b0001000,
        S_RESP   = 7'b0010000,
        S_DRD    = 7'b0100000,
        S_DOUT   = 7'b1000000
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [VW-1:0]   r_value, n_value;
    logic [CW-1:0]   r_ptr, n_ptr;
    logic            r_pend, n_pend;
    logic [CW-1:0]   r_idx, n_idx;
    logic [DW-1:0]   r_cur, n_cur;
    logic [CW-1:0]   r_left, n_left;
    logic [AW-1:0]   r_wa, n_wa;
    logic            r_up, n_up;
    t_status         r_status, n_status;

    logic [VW-1:0]   rd_start, rd_end, cur_start, cur_end;
    logic [VW:0]     v_x, v_p1, rd_e1, cur_e1;
    logic            has_cur, is_present, is_ext, is_merge, is_pre, is_full;
    logic            dump_last;

    assign {rd_start, rd_end}   = i_ram_rd_data;
    assign {cur_start, cur_end} = r_cur;

    // Adjacency is tested one bit wider so that the top value does not wrap.
    assign v_x    = {1'b0, r_value};
    assign v_p1   = v_x + (VW+1)'(1);
    assign rd_e1  = {1'b0, rd_end} + (VW+1)'(1);
    assign cur_e1 = {1'b0, cur_end} + (VW+1)'(1);

    assign has_cur    = r_idx < r_count;
    assign is_present = has_cur && (cur_start <= r_value) && (r_value <= cur_end);
    assign is_ext     = has_cur && (cur_e1 == v_x);
    assign is_merge   = is_ext && r_pend && ({1'b0, rd_start} == v_p1);
    assign is_pre     = has_cur && ({1'b0, cur_start} == v_p1);
    assign is_full    = r_count == CW'(MAX_INTERVALS);
    assign dump_last  = (r_ptr + CW'(1)) == r_count;

    assign i_req.ready = r_state == S_IDLE;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_value  = r_value;
        n_ptr    = r_ptr;
        n_pend   = r_pend;
        n_idx    = r_idx;
        n_cur    = r_cur;
        n_left   = r_left;
        n_wa     = r_wa;
        n_up     = r_up;
        n_status = r_status;

        o_ram_wr_en   = 1'b0;
        o_ram_wr_addr = r_wa;
        o_ram_wr_data = i_ram_rd_data;
        o_ram_rd_en   = 1'b0;
        o_ram_rd_addr = r_ptr[AW-1:0];

        o_rslt.valid  = 1'b0;
        o_rslt.status = r_status;
        o_rslt.last   = 1'b1;
        o_rslt_start  = '0;
        o_rslt_end    = '0;
        o_rslt_count  = r_count;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_value = i_req.value;
                    n_ptr   = '0;
                    n_pend  = 1'b0;
                    if (i_req.opcode == OP_DUMP) begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_RESP;
                        end else begin
                            n_state = S_DRD;
                        end
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            // One read is issued per cycle; pending data always belongs to r_ptr - 1.
            S_SCAN: begin
                if (r_ptr < r_count) begin
                    o_ram_rd_en = 1'b1;
                end
                if (r_pend && (rd_e1 >= v_x)) begin
                    // The read issued now fetches the following entry, if any.
                    n_idx   = r_ptr - CW'(1);
                    n_cur   = i_ram_rd_data;
                    n_pend  = r_ptr < r_count;
                    n_state = S_DECIDE;
                end else if (!r_pend && (r_ptr == r_count)) begin
                    n_idx   = r_count;
                    n_pend  = 1'b0;
                    n_state = S_DECIDE;
                end else begin
                    n_pend = r_ptr < r_count;
                    if (r_ptr < r_count) begin
                        n_ptr = r_ptr + CW'(1);
                    end
                end
            end

            S_DECIDE: begin
                n_status = ST_ADDED;
                n_pend   = 1'b0;
                o_ram_wr_addr = r_idx[AW-1:0];
                priority if (is_present) begin
                    n_status = ST_PRESENT;
                    n_state  = S_RESP;
                end else if (is_merge) begin
                    o_ram_wr_en   = 1'b1;
                    o_ram_wr_data = {cur_start, rd_end};
                    n_up    = 1'b0;
                    n_ptr   = r_idx + CW'(2);
                    n_left  = r_count - r_idx - CW'(2);
                    n_wa    = AW'(r_idx + CW'(1));
                    n_state = S_SHIFT;
                end else if (is_ext) begin
                    o_ram_wr_en   = 1'b1;
                    o_ram_wr_data = {cur_start, r_value};
                    n_state = S_RESP;
                end else if (is_pre) begin
                    o_ram_wr_en   = 1'b1;
                    o_ram_wr_data = {r_value, cur_end};
                    n_state = S_RESP;
                end else if (is_full) begin
                    n_status = ST_FULL;
                    n_state  = S_RESP;
                end else begin
                    n_up    = 1'b1;
                    n_ptr   = r_count - CW'(1);
                    n_left  = r_count - r_idx;
                    n_wa    = AW'(r_count);
                    n_state = S_SHIFT;
                end
            end

            // Moves entries by one place: each read is written back at r_wa in the next cycle.
            S_SHIFT: begin
                if (r_pend) begin
                    o_ram_wr_en = 1'b1;
                    n_wa = r_up ? r_wa - AW'(1) : r_wa + AW'(1);
                end
                if (r_left != '0) begin
                    o_ram_rd_en = 1'b1;
                    n_ptr  = r_up ? r_ptr - CW'(1) : r_ptr + CW'(1);
                    n_left = r_left - CW'(1);
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if ((r_left == '0) && !r_pend) begin
                    if (r_up) begin
                        o_ram_wr_en   = 1'b1;
                        o_ram_wr_addr = r_idx[AW-1:0];
                        o_ram_wr_data = {r_value, r_value};
                        n_count = r_count + CW'(1);
                    end else begin
                        n_count = r_count - CW'(1);
                    end
                    n_state = S_RESP;
                end
            end

            S_RESP: begin
                o_rslt.valid = 1'b1;
                if (i_rslt_free) begin
                    n_state = S_IDLE;
                end
            end

            S_DRD: begin
                o_ram_rd_en = 1'b1;
                n_state     = S_DOUT;
            end

            // The RAM output holds while no read is issued, so the record waits here.
            S_DOUT: begin
                o_rslt.valid  = 1'b1;
                o_rslt.status = ST_RECORD;
                o_rslt.last   = dump_last;
                o_rslt_start  = rd_start;
                o_rslt_end    = rd_end;
                if (i_rslt_free) begin
                    if (dump_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ptr   = r_ptr + CW'(1);
                        n_state = S_DRD;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value  <= n_value;
        r_ptr    <= n_ptr;
        r_idx    <= n_idx;
        r_cur    <= n_cur;
        r_left   <= n_left;
        r_wa     <= n_wa;
        r_up     <= n_up;
        r_status <= n_status;
    end

endmodule

@@ hdl/dis_out.sv @@
module dis_out import dis_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int COUNT_WIDTH = $clog2(MAX_INTERVALS_DEF + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_rslt_ctl              i_rslt,
    input  logic [VALUE_WIDTH-1:0] i_rslt_start,
    input  logic [VALUE_WIDTH-1:0] i_rslt_end,
    input  logic [COUNT_WIDTH-1:0] i_rslt_count,
    output logic                   o_rslt_free,
    dis_rsp_if.source              o_rsp
);

    logic                   r_valid;
    t_status                r_status;
    logic [VALUE_WIDTH-1:0] r_start;
    logic [VALUE_WIDTH-1:0] r_end;
    logic [COUNT_WIDTH-1:0] r_count;
    logic                   r_last;

    assign o_rslt_free = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_rslt_free) begin
            r_valid <= i_rslt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rslt_free && i_rslt.valid) begin
            r_status <= i_rslt.status;
            r_start  <= i_rslt_start;
            r_end    <= i_rslt_end;
            r_count  <= i_rslt_count;
            r_last   <= i_rslt.last;
        end
    end

    assign o_rsp.valid          = r_valid;
    assign o_rsp.status         = r_status;
    assign o_rsp.interval_start = r_start;
    assign o_rsp.interval_end   = r_end;
    assign o_rsp.interval_count = r_count;
    assign o_rsp.last_of_run    = r_last;

endmodule

@@ hdl/disjoint_interval_set.sv @@
// Sorted set of disjoint, non-adjacent intervals held as start/end pairs in one
// single-port-read RAM. One transaction at a time is processed. An add scans the
// table from the bottom, one entry per cycle, until it meets the first interval
// that reaches the value, then extends, merges, prepends or inserts; a merge or
// insert moves the later entries by one place at one entry per cycle. A dump
// reads each interval through the registered RAM read and issues the next read
// only once the output stage has taken the current interval, and a dump of an
// empty table gives a single empty-status result. Results leave through an
// output register; the sequencer's final step waits only while an earlier
// result is still held there. The table contents are undefined after reset;
// only the interval count is cleared, and no clearing pass is needed.
module disjoint_interval_set import dis_pkg::*; #(
    parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
    parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dis_req_if.sink   i_req,
    dis_rsp_if.source o_rsp
);

    localparam int AW = $clog2(MAX_INTERVALS);
    localparam int CW = $clog2(MAX_INTERVALS + 1);
    localparam int DW = 2 * VALUE_WIDTH;

    logic                   ram_wr_en;
    logic [AW-1:0]          ram_wr_addr;
    logic [DW-1:0]          ram_wr_data;
    logic                   ram_rd_en;
    logic [AW-1:0]          ram_rd_addr;
    logic [DW-1:0]          ram_rd_data;

    t_rslt_ctl              rslt;
    logic [VALUE_WIDTH-1:0] rslt_start;
    logic [VALUE_WIDTH-1:0] rslt_end;
    logic [CW-1:0]          rslt_count;
    logic                   rslt_free;

    dis_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_INTERVALS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    dis_seq #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .VALUE_WIDTH   (VALUE_WIDTH)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (i_req),
        .o_ram_wr_en   (ram_wr_en),
        .o_ram_wr_addr (ram_wr_addr),
        .o_ram_wr_data (ram_wr_data),
        .o_ram_rd_en   (ram_rd_en),
        .o_ram_rd_addr (ram_rd_addr),
        .i_ram_rd_data (ram_rd_data),
        .o_rslt        (rslt),
        .o_rslt_start  (rslt_start),
        .o_rslt_end    (rslt_end),
        .o_rslt_count  (rslt_count),
        .i_rslt_free   (rslt_free)
    );

    dis_out #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .COUNT_WIDTH (CW)
    ) u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rslt       (rslt),
        .i_rslt_start (rslt_start),
        .i_rslt_end   (rslt_end),
        .i_rslt_count (rslt_count),
        .o_rslt_free  (rslt_free),
        .o_rsp        (o_rsp)
    );

endmodule

@@ hdl/dis_chk.sv @@
module dis_chk import dis_pkg::*; #(
    parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
    parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
    localparam int CW           = $clog2(MAX_INTERVALS + 1)
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_valid,
    input logic                   i_ready,
    input logic [STATUS_W-1:0]    i_status,
    input logic [VALUE_WIDTH-1:0] i_start,
    input logic [VALUE_WIDTH-1:0] i_end,
    input logic [CW-1:0]          i_count,
    input logic                   i_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable({i_status, i_start, i_end, i_count, i_last}))
        else $error("result transaction changed while stalled");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status != ST_RECORD) |-> (i_start == '0) && (i_end == '0))
        else $error("non-record result carries interval bounds");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status == ST_RECORD) |-> (i_start <= i_end) && (i_count != '0))
        else $error("interval record out of order or from an empty table");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status == ST_FULL) |-> i_count == CW'(MAX_INTERVALS))
        else $error("value dropped while the table was not full");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status == ST_EMPTY) |-> (i_count == '0) && i_last)
        else $error("empty-table result with intervals held or not last");

endmodule

bind disjoint_interval_set dis_chk #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .VALUE_WIDTH   (VALUE_WIDTH)
) u_dis_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_rsp.valid),
    .i_ready  (o_rsp.ready),
    .i_status (o_rsp.status),
    .i_start  (o_rsp.interval_start),
    .i_end    (o_rsp.interval_end),
    .i_count  (o_rsp.interval_count),
    .i_last   (o_rsp.last_of_run)
);

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import dis_pkg::*;

    localparam int MAX_SPANS       = MAX_INTERVALS_DEF;
    localparam int VW              = VALUE_WIDTH_DEF;
    localparam int COUNT_W         = $clog2(MAX_SPANS + 1);
    localparam int VALUE_SPAN      = 1 << VW;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int SETTLE_CYCLES   = 64;
    localparam int ITEMS_PER_PHASE = 48;

    typedef struct packed {
        t_status             status;
        logic [VW-1:0]       lo;
        logic [VW-1:0]       hi;
        logic [COUNT_W-1:0]  count;
        logic                is_last;
    } t_report;

    logic i_clk;
    logic i_rst_n;

    dis_req_if req_if ();
    dis_rsp_if rsp_if ();

    disjoint_interval_set DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Predicted contents of the interval table.
    logic [VW-1:0] span_lo [MAX_SPANS];
    logic [VW-1:0] span_hi [MAX_SPANS];
    int            span_count = 0;

    t_report reports_due [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count     = 0;
    int items_sent     = 0;
    int cycle_count    = 0;
    int status_hits [5] = '{default: 0};

    always #1 i_clk = ~i_clk;

    function automatic t_status fold_value(logic [VW-1:0] v);
        int n;
        int i;
        int k;
        n = span_count;
        i = 0;
        // Skip every span that ends more than one below the value.
        while (i < n && int'(span_hi[i]) + 1 < int'(v))
            i++;
        if (i < n && span_lo[i] <= v && v <= span_hi[i])
            return ST_PRESENT;
        if (i < n && int'(span_hi[i]) + 1 == int'(v)) begin
            span_hi[i] = v;
            if (i + 1 < n && int'(span_lo[i + 1]) == int'(v) + 1) begin
                span_hi[i] = span_hi[i + 1];
                for (k = i + 1; k + 1 < n; k++) begin
                    span_lo[k] = span_lo[k + 1];
                    span_hi[k] = span_hi[k + 1];
                end
                span_count--;
            end
            return ST_ADDED;
        end
        if (i < n && int'(span_lo[i]) == int'(v) + 1) begin
            span_lo[i] = v;
            return ST_ADDED;
        end
        if (n >= MAX_SPANS)
            return ST_FULL;
        for (k = n; k > i; k--) begin
            span_lo[k] = span_lo[k - 1];
            span_hi[k] = span_hi[k - 1];
        end
        span_lo[i] = v;
        span_hi[i] = v;
        span_count = n + 1;
        return ST_ADDED;
    endfunction

    function automatic void predict_reports(t_opcode op, logic [VW-1:0] v);
        t_status st;
        if (op == OP_ADD) begin
            st = fold_value(v);
            reports_due.push_back('{st, '0, '0, COUNT_W'(span_count), 1'b1});
        end else if (span_count == 0) begin
            reports_due.push_back('{ST_EMPTY, '0, '0, '0, 1'b1});
        end else begin
            for (int k = 0; k < span_count; k++)
                reports_due.push_back('{ST_RECORD, span_lo[k], span_hi[k],
                                        COUNT_W'(span_count), k == span_count - 1});
        end
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endfunction

    task automatic send_item(t_opcode op, int v);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid  <= 1'b1;
        req_if.opcode <= op;
        req_if.value  <= VW'(v);
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        predict_reports(op, VW'(v));
        items_sent++;
    endtask

    always @(negedge i_clk)
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge i_clk) begin : check_results
        t_report want;
        if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (reports_due.size() == 0) begin
                $error("Result with nothing outstanding: status %0d", rsp_if.status);
                fail_count++;
            end else begin
                want = reports_due.pop_front();
                status_hits[int'(want.status)]++;
                check_field("status", 32'(want.status), 32'(rsp_if.status));
                check_field("interval_start", 32'(want.lo), 32'(rsp_if.interval_start));
                check_field("interval_end", 32'(want.hi), 32'(rsp_if.interval_end));
                check_field("interval_count", 32'(want.count), 32'(rsp_if.interval_count));
                check_field("last_of_run", 32'(want.is_last), 32'(rsp_if.last_of_run));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, reports_due.size());
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic test_empty_dump();
        send_item(OP_DUMP, $urandom_range(0, VALUE_SPAN - 1));
    endtask

    task automatic test_add_cases();
        send_item(OP_ADD, 100);     // insert into an empty table
        send_item(OP_ADD, 100);     // already covered
        send_item(OP_ADD, 101);     // extend the end
        send_item(OP_ADD, 99);      // extend the start
        // A value lying before an interval, but not next to it, is a new interval.
        send_item(OP_ADD, 96);
        send_item(OP_ADD, 98);
        send_item(OP_ADD, 97);      // closes the gap between two neighbors
    endtask

    task automatic test_extremes();
        send_item(OP_ADD, VALUE_SPAN - 1);
        send_item(OP_ADD, 0);
        send_item(OP_ADD, VALUE_SPAN - 2);
        send_item(OP_ADD, 1);
    endtask

    task automatic test_table_full();
        int fill_v;
        fill_v = 300;
        while (span_count < MAX_SPANS) begin
            send_item(OP_ADD, fill_v);
            fill_v += 2;
        end
        send_item(OP_ADD, 500);         // needs a new entry, so it is dropped
        send_item(OP_ADD, fill_v - 1);  // extending still works on a full table
        send_item(OP_ADD, 299);
        send_item(OP_ADD, 301);         // so does a merge
        send_item(OP_DUMP, $urandom_range(0, VALUE_SPAN - 1));
    endtask

    // One burst of adds aimed at a narrow window, with some dumps and scattered
    // values mixed in. Half of the windows are then filled completely so that
    // spans coalesce and the table count falls again.
    task automatic run_window();
        int width;
        int base;
        int offset;
        int n;
        int pick;
        bit rising;
        width = $urandom_range(4, 20);
        pick  = $urandom_range(0, 7);
        if (span_count > 0 && pick < 4) begin
            offset = $urandom_range(0, 6);
            base   = int'(span_lo[$urandom_range(0, span_count - 1)]) - offset;
            if (base < 0)
                base = 0;
        end else if (pick == 4) begin
            base = 0;
        end else if (pick == 5) begin
            base = VALUE_SPAN - width;
        end else begin
            base = $urandom_range(0, VALUE_SPAN - width);
        end
        if (base > VALUE_SPAN - width)
            base = VALUE_SPAN - width;
        n = width + $urandom_range(0, width);
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
                send_item(OP_DUMP, $urandom_range(0, VALUE_SPAN - 1));
            else if (pick < 10)
                send_item(OP_ADD, $urandom_range(0, VALUE_SPAN - 1));
            else
                send_item(OP_ADD, base + $urandom_range(0, width - 1));
        end
        if ($urandom_range(0, 1)) begin
            rising = 1'($urandom_range(0, 1));
            for (int k = 0; k < width; k++)
                send_item(OP_ADD, rising ? base + k : base + width - 1 - k);
        end
        send_item(OP_DUMP, $urandom_range(0, VALUE_SPAN - 1));
    endtask

    task automatic test_random(int sender_idle, int receiver_stall);
        int phase_start;
        send_idle_pct  = sender_idle;
        recv_stall_pct = receiver_stall;
        phase_start    = items_sent;
        while (items_sent - phase_start < ITEMS_PER_PHASE)
            run_window();
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        req_if.valid  = 1'b0;
        req_if.opcode = OP_ADD;
        req_if.value  = '0;
        rsp_if.ready  = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_dump();
        test_add_cases();
        test_extremes();
        test_table_full();
        test_random(0, 0);
        test_random(72, 0);
        test_random(0, 72);
        test_random(33, 33);

        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d transactions under four idle and stall patterns; %0d results checked.",
                 items_sent, status_hits.sum());
        $display("Added %0d, present %0d, dropped full %0d, interval records %0d, empty %0d.",
                 status_hits[ST_ADDED], status_hits[ST_PRESENT], status_hits[ST_FULL],
                 status_hits[ST_RECORD], status_hits[ST_EMPTY]);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ disjoint_interval_set.f @@
hdl/dis_pkg.sv
hdl/dis_if.sv
hdl/dis_ram.sv
hdl/dis_seq.sv
hdl/dis_out.sv
hdl/disjoint_interval_set.sv
hdl/dis_chk.sv
bench/tb.sv
